/* design/a2sm_pkg.sv */
// Shared types and constants for the address to span map.
`default_nettype none

package a2sm_pkg;

   // Fixed field widths
   localparam int ADDR_W     = 28;
   localparam int SIZE_W     = 28;
   localparam int ID_W       = 16;
   localparam int OFFSET_W   = 16;
   localparam int SLOT_OUT_W = 12;
   localparam int EXTRA_W    = 4;
   localparam int CSR_DATA_W = 4;

   // Default geometry
   localparam int SPAN_SHIFT_DEF   = 16;
   localparam int INDEX_BITS_DEF   = 12;
   localparam int PAGE_BITS_DEF    = 6;
   localparam int MAX_FALLBACK_DEF = 8;

   // Register reset values
   localparam logic [EXTRA_W-1:0] FALLBACK_EXTRA_RST = 4'd4;
   localparam logic               PAGE_STOP_RST      = 1'b1;

   typedef enum logic [1:0] {
      OP_FIND   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_MISS     = 2'd1,
      ST_OCCUPIED = 2'd2,
      ST_MISMATCH = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_FALLBACK_EXTRA = 1'd0,
      CSR_PAGE_STOP      = 1'd1
   } csr_index_type;

   typedef struct packed {
      opcode_type          opcode;
      logic [ADDR_W-1:0]   address;
      logic [SIZE_W-1:0]   span_size;
      logic [ID_W-1:0]     span_id;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [ID_W-1:0]         found_id;
      logic [SLOT_OUT_W-1:0]   slot_index;
   } rsp_type;

   // One slot table word
   typedef struct packed {
      logic                  valid;
      logic [OFFSET_W-1:0]   base_off;
      logic [SIZE_W-1:0]     size;
      logic [ID_W-1:0]       id;
   } slot_type;

endpackage

`default_nettype wire

/* design/a2sm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module a2sm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/address_to_span_map.sv */
// Span slot table with find, insert and remove, walked by a small sequencer.
//
//   channel   direction   handshake            beat
//   req       in          req_valid/req_ready  req_data (opcode, address, size, id)
//   rsp       out         rsp_valid/rsp_ready  rsp_data (status, found_id, slot_index)
//   csr       in          csr_we               csr_index, csr_wdata
//
// Insert, remove and a find that hits its home slot pass through S_HOME to
// S_FINISH; an unused opcode or a find whose home page is absent goes straight
// to S_FINISH. Each slot walked back costs one read of the slot table in S_STEP
// and one check on the shared subtractor in S_PROBE, and a walk that ends
// without a decision passes through S_STEP once more.
// After reset a clearing pass writes all 2**INDEX_BITS slots, one per cycle;
// req_ready stays low until it ends.
// A result waits in the output register; the next beat is taken meanwhile and
// the sequencer holds before writing its own result until that register frees.
`default_nettype none

module address_to_span_map #(
   parameter int SPAN_SHIFT   = a2sm_pkg::SPAN_SHIFT_DEF,
   parameter int INDEX_BITS   = a2sm_pkg::INDEX_BITS_DEF,
   parameter int PAGE_BITS    = a2sm_pkg::PAGE_BITS_DEF,
   parameter int MAX_FALLBACK = a2sm_pkg::MAX_FALLBACK_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  a2sm_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output a2sm_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  a2sm_pkg::csr_index_type              csr_index,
   input  logic [a2sm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import a2sm_pkg::*;

   localparam int SLOT_CNT = 2 ** INDEX_BITS;
   localparam int CMP_W    = (ADDR_W > SPAN_SHIFT + INDEX_BITS) ? ADDR_W
                                                               : SPAN_SHIFT + INDEX_BITS;
   localparam int OFF_W    = (SPAN_SHIFT < OFFSET_W) ? SPAN_SHIFT : OFFSET_W;
   localparam int PG_W     = (INDEX_BITS > PAGE_BITS) ? INDEX_BITS - PAGE_BITS : 1;
   localparam int PAGE_CNT = (INDEX_BITS > PAGE_BITS) ? 2 ** (INDEX_BITS - PAGE_BITS) : 1;
   localparam int LOW_W    = (PAGE_BITS < INDEX_BITS) ? PAGE_BITS : INDEX_BITS;
   localparam int CNT_W    = $clog2(MAX_FALLBACK + 2);
   localparam int SAT_W    = (CNT_W > EXTRA_W) ? CNT_W : EXTRA_W;
   localparam int WORD_W   = $bits(slot_type);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HOME,
      S_STEP,
      S_PROBE,
      S_FINISH
   } state_type;

   function automatic logic [PG_W-1:0] page_of(input logic [INDEX_BITS-1:0] idx);
      return PG_W'(idx >> PAGE_BITS);
   endfunction

   function automatic logic [SLOT_OUT_W-1:0] slot_out(input logic [INDEX_BITS-1:0] idx);
      logic [SLOT_OUT_W+INDEX_BITS-1:0] wide;
      wide = {{SLOT_OUT_W{1'b0}}, idx};
      return wide[SLOT_OUT_W-1:0];
   endfunction

   state_type               state_ff, state_in;
   logic [INDEX_BITS-1:0]   clr_ff, clr_in;
   opcode_type              op_ff, op_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [SIZE_W-1:0]       size_ff, size_in;
   logic [ID_W-1:0]         id_ff, id_in;
   logic [INDEX_BITS-1:0]   cur_ff, cur_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   rsp_type                 res_ff, res_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [EXTRA_W-1:0]      extra_ff, extra_in;
   logic                    pstop_ff, pstop_in;
   logic [PAGE_CNT-1:0]     page_ff, page_in;

   logic                    ram_wr_en;
   logic [INDEX_BITS-1:0]   ram_wr_addr;
   slot_type                ram_wr_word;
   logic                    ram_rd_en;
   logic [INDEX_BITS-1:0]   ram_rd_addr;
   logic [WORD_W-1:0]       ram_rd_data;
   slot_type                slot_rd;

   logic [CMP_W-1:0]        req_ext;
   logic [INDEX_BITS-1:0]   req_idx;
   logic [CMP_W-1:0]        addr_ext;
   logic [CMP_W-1:0]        base_ext;
   logic [CMP_W:0]          diff_full;
   logic                    below_base;
   logic                    in_span;
   logic [SAT_W-1:0]        extra_wide;
   logic [SAT_W-1:0]        extra_sat;
   logic [CNT_W-1:0]        steps;
   logic [INDEX_BITS-1:0]   prev_idx;
   logic                    walk_stop;

   a2sm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOT_CNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_word),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign slot_rd = ram_rd_data;

   // Home slot of an incoming beat
   assign req_ext = CMP_W'(req_data.address);
   assign req_idx = req_ext[SPAN_SHIFT +: INDEX_BITS];

   // Shared subtractor: address minus base of the slot just read
   assign addr_ext   = CMP_W'(addr_ff);
   assign base_ext   = CMP_W'({cur_ff, SPAN_SHIFT'(slot_rd.base_off)});
   assign diff_full  = {1'b0, addr_ext} - {1'b0, base_ext};
   assign below_base = diff_full[CMP_W];
   assign in_span    = !below_base && (diff_full[CMP_W-1:0] < CMP_W'(slot_rd.size));

   assign extra_wide = SAT_W'(extra_ff);
   assign extra_sat  = (extra_wide > SAT_W'(MAX_FALLBACK)) ? SAT_W'(MAX_FALLBACK) : extra_wide;
   assign steps      = CNT_W'(extra_sat) + CNT_W'(1);

   assign prev_idx  = cur_ff - 1'b1;
   assign walk_stop = (left_ff == '0) || (cur_ff == '0) ||
                      (pstop_ff && (cur_ff[LOW_W-1:0] == '0) && !page_ff[page_of(prev_idx)]);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      size_in      = size_ff;
      id_in        = id_ff;
      cur_in       = cur_ff;
      left_in      = left_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      extra_in     = extra_ff;
      pstop_in     = pstop_ff;
      page_in      = page_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cur_ff;
      ram_wr_word  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = req_idx;

      if (csr_we) begin
         case (csr_index)
            CSR_FALLBACK_EXTRA: extra_in = EXTRA_W'(csr_wdata);
            CSR_PAGE_STOP:      pstop_in = csr_wdata[0];
            default:            extra_in = extra_ff;
         endcase
      end

      // Drop the output beat once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.opcode;
               addr_in   = req_data.address;
               size_in   = req_data.span_size;
               id_in     = req_data.span_id;
               cur_in    = req_idx;
               ram_rd_en = 1'b1;
               if ((req_data.opcode != OP_FIND && req_data.opcode != OP_INSERT &&
                    req_data.opcode != OP_REMOVE) ||
                   (req_data.opcode == OP_FIND && pstop_ff &&
                    !page_ff[page_of(req_idx)])) begin
                  res_in   = '{status: ST_MISS, found_id: '0, slot_index: '0};
                  state_in = S_FINISH;
               end else begin
                  state_in = S_HOME;
               end
            end
         end
         S_HOME: begin
            case (op_ff)
               OP_INSERT: begin
                  ram_wr_en                = 1'b1;
                  ram_wr_word.valid        = 1'b1;
                  ram_wr_word.base_off     = OFFSET_W'(addr_ff[OFF_W-1:0]);
                  ram_wr_word.size         = size_ff;
                  ram_wr_word.id           = id_ff;
                  page_in[page_of(cur_ff)] = 1'b1;
                  res_in   = '{status: slot_rd.valid ? ST_OCCUPIED : ST_OK,
                               found_id: '0, slot_index: slot_out(cur_ff)};
                  state_in = S_FINISH;
               end
               OP_REMOVE: begin
                  ram_wr_en                = 1'b1;
                  page_in[page_of(cur_ff)] = 1'b1;
                  res_in   = '{status: (!slot_rd.valid || slot_rd.id != id_ff) ?
                                       ST_MISMATCH : ST_OK,
                               found_id: '0, slot_index: slot_out(cur_ff)};
                  state_in = S_FINISH;
               end
               default: begin
                  if (slot_rd.valid && !below_base) begin
                     res_in   = '{status: ST_OK, found_id: slot_rd.id,
                                  slot_index: slot_out(cur_ff)};
                     state_in = S_FINISH;
                  end else begin
                     left_in  = steps;
                     state_in = S_STEP;
                  end
               end
            endcase
         end
         S_STEP: begin
            if (walk_stop) begin
               res_in   = '{status: ST_MISS, found_id: '0, slot_index: '0};
               state_in = S_FINISH;
            end else begin
               cur_in      = prev_idx;
               left_in     = left_ff - 1'b1;
               ram_rd_en   = 1'b1;
               ram_rd_addr = prev_idx;
               state_in    = S_PROBE;
            end
         end
         S_PROBE: begin
            // First valid slot on the way back decides the find
            if (slot_rd.valid) begin
               if (in_span) begin
                  res_in = '{status: ST_OK, found_id: slot_rd.id,
                             slot_index: slot_out(cur_ff)};
               end else begin
                  res_in = '{status: ST_MISS, found_id: '0, slot_index: '0};
               end
               state_in = S_FINISH;
            end else begin
               state_in = S_STEP;
            end
         end
         S_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         extra_ff     <= FALLBACK_EXTRA_RST;
         pstop_ff     <= PAGE_STOP_RST;
         page_ff      <= '0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         extra_ff     <= extra_in;
         pstop_ff     <= pstop_in;
         page_ff      <= page_in;
         left_ff      <= left_in;
      end
      op_ff   <= op_in;
      addr_ff <= addr_in;
      size_ff <= size_in;
      id_ff   <= id_in;
      cur_ff  <= cur_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The slot table is never read and written in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("slot table read and write in the same cycle");

   // A probed slot is always the one below the slot checked before it
   a_probe_steps_back: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (cur_ff == $past(prev_idx)))
      else $error("walk did not step back by one slot");

   // The walk never runs past its saturated step budget
   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP || state_ff == S_PROBE) |->
         (left_ff <= CNT_W'(MAX_FALLBACK + 1)))
      else $error("walk step count out of range");

   // Insert and remove leave the home page marked present
   a_page_marked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOME && op_ff != OP_FIND) |=> page_ff[page_of(cur_ff)])
      else $error("home page not marked present after update");

   // A finished result reaches the output once the register is free
   a_result_issued: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && (!rsp_valid_ff || rsp_ready)) |=>
         (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result not moved to the output register");

endmodule

`default_nettype wire
